@@ rtl/bbsm_pkg.sv @@
// Package for the base-b softmax unit: shared constants, the
// controller/datapath command and status structs, and the 2^-(2^-i) root table.
// No dependencies.
package bbsm_pkg;

    localparam int VEC_MAX_DEF = 64;
    localparam int X_W         = 16;
    localparam int CFG_W       = 16;
    localparam int TERM_W      = 32;
    localparam int SUM_W       = 24;
    localparam int PROB_W      = 16;
    localparam int IDX_W       = 6;
    localparam int FRAC_BITS   = 20;
    localparam int P_W         = 31;   // Q1.30 running product
    localparam int ROOT_W      = 30;
    localparam int E_W         = 17;   // Q1.16 exponent
    localparam int NUM_W       = 34;   // divider numerator
    localparam int Q_W         = 18;
    localparam int OUT_DATA_W  = 24;
    localparam logic signed [CFG_W-1:0] LOG2_BASE_RST = 16'sd23637;

    typedef struct packed {
        logic load;       // store an input item
        logic clr_vec;    // clear vector state
        logic idx_clr;
        logic idx_inc;
        logic rd;         // read term store at current index
        logic exp_start;  // latch d = max - term
        logic exp_step;
        logic acc;        // add e into sum
        logic div_start;
        logic div_step;
        logic emit;       // load output register
    } t_cmd;

    typedef struct packed {
        logic exp_done;
        logic div_done;
        logic idx_last;
        logic out_free;
    } t_sts;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int n = 0; n < 32; n++) begin
            if (b > v) b = b >> 2;
        end
        for (int n = 0; n < 32; n++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // r_0 = 2^29, r_i = isqrt(r_(i-1) * 2^30), packed 30 bits per entry
    function automatic logic [(FRAC_BITS+1)*ROOT_W-1:0] calc_roots();
        logic [(FRAC_BITS+1)*ROOT_W-1:0] res;
        logic [63:0] r;
        r = 64'd1 << 29;
        res = '0;
        res[0 +: ROOT_W] = r[ROOT_W-1:0];
        for (int i = 1; i <= FRAC_BITS; i++) begin
            r = isqrt64(r << 30);
            res[i*ROOT_W +: ROOT_W] = r[ROOT_W-1:0];
        end
        return res;
    endfunction

    localparam logic [(FRAC_BITS+1)*ROOT_W-1:0] ROOTS_FLAT = calc_roots();

endpackage

@@ rtl/bbsm_ctrl.sv @@
// Sequencer for the base-b softmax unit: load, sum pass, normalise pass.
// Depends on bbsm_pkg.
module bbsm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  bbsm_pkg::t_sts i_sts,
    output bbsm_pkg::t_cmd o_cmd
);
    import bbsm_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_SUM_RD    = 11'b000_0000_0010,
        S_SUM_LD    = 11'b000_0000_0100,
        S_SUM_EXP   = 11'b000_0000_1000,
        S_SUM_ACC   = 11'b000_0001_0000,
        S_DIV_RD    = 11'b000_0010_0000,
        S_DIV_LD    = 11'b000_0100_0000,
        S_DIV_EXP   = 11'b000_1000_0000,
        S_DIV_START = 11'b001_0000_0000,
        S_DIV_RUN   = 11'b010_0000_0000,
        S_EMIT      = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state = S_SUM_RD;
                    end
                end
            end
            S_SUM_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_SUM_LD;
            end
            S_SUM_LD: begin
                o_cmd.exp_start = 1'b1;
                n_state = S_SUM_EXP;
            end
            S_SUM_EXP: begin
                o_cmd.exp_step = 1'b1;
                if (i_sts.exp_done) n_state = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_DIV_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SUM_RD;
                end
            end
            S_DIV_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_DIV_LD;
            end
            S_DIV_LD: begin
                o_cmd.exp_start = 1'b1;
                n_state = S_DIV_EXP;
            end
            S_DIV_EXP: begin
                o_cmd.exp_step = 1'b1;
                if (i_sts.exp_done) n_state = S_DIV_START;
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.clr_vec = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_DIV_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/bbsm_datapath.sv @@
// Datapath for the base-b softmax unit: term store, max/sum registers,
// iterative 2^-d unit, bit-serial divider and output register. Depends on bbsm_pkg.
module bbsm_datapath #(
    parameter int VEC_MAX = bbsm_pkg::VEC_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [bbsm_pkg::CFG_W-1:0]       i_cfg_wr_data,
    input  logic [bbsm_pkg::X_W-1:0]         i_x,
    input  bbsm_pkg::t_cmd                   i_cmd,
    output bbsm_pkg::t_sts                   o_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bbsm_pkg::OUT_DATA_W-1:0]  o_out_data,
    output logic                             o_out_last,
    output logic                             o_out_trunc
);
    import bbsm_pkg::*;

    localparam int AW    = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1;
    localparam int CNT_W = $clog2(VEC_MAX + 1);

    logic signed [CFG_W-1:0]  r_log2_base;
    logic signed [TERM_W-1:0] r_mem [VEC_MAX];
    logic signed [TERM_W-1:0] r_rdata;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         r_idx;
    logic signed [TERM_W-1:0] r_max;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_ovf;

    logic [TERM_W-1:0]        r_d;
    logic [P_W-1:0]           r_p;
    logic [4:0]               r_j;

    logic [NUM_W-1:0]         r_num;
    logic [SUM_W-1:0]         r_rem;
    logic [Q_W-1:0]           r_q;
    logic [5:0]               r_dc;

    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;
    logic                     r_out_last;
    logic                     r_out_trunc;

    logic signed [TERM_W-1:0] term;
    logic [4:0]               root_sel;
    logic [ROOT_W-1:0]        root;
    logic [61:0]              prod;
    logic [P_W-1:0]           p_next;
    logic [11:0]              k;
    logic [32:0]              e_wide;
    logic [E_W-1:0]           e;
    logic [SUM_W:0]           rem_sh;
    logic                     q_bit;
    logic [PROB_W-1:0]        prob;

    // x (Q8.8) * log2_base (Q4.12) -> Q12.20
    assign term = TERM_W'($signed(i_x) * r_log2_base);

    // one rounded multiply per set fraction bit, lowest bit first
    assign root_sel = 5'(FRAC_BITS) - r_j;
    assign root     = ROOTS_FLAT[root_sel*ROOT_W +: ROOT_W];
    assign prod     = 62'(r_p) * 62'(root) + (62'd1 << 29);
    assign p_next   = prod[60:30];

    assign k = r_d[31:20];
    always_comb begin
        e_wide = '0;
        if (k <= 12'd16) begin
            e_wide = (33'(r_p) + (33'd1 << (k[4:0] + 5'd13))) >> (k[4:0] + 5'd14);
        end
    end
    assign e = e_wide[E_W-1:0];

    // restoring division step
    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_sum});

    always_comb begin
        if (r_sum == '0) prob = '0;
        else if (r_q > Q_W'(16'hFFFF)) prob = 16'hFFFF;
        else prob = r_q[PROB_W-1:0];
    end

    assign o_sts.exp_done = (r_j == 5'(FRAC_BITS - 1));
    assign o_sts.div_done = (r_dc == 6'(NUM_W - 1));
    assign o_sts.idx_last = ((r_idx + 1'b1) == r_cnt);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // term store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_cnt < CNT_W'(VEC_MAX))) begin
            r_mem[r_cnt[AW-1:0]] <= term;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_idx[AW-1:0]];
        end
    end

    // control state and vector registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_base <= LOG2_BASE_RST;
            r_cnt       <= '0;
            r_max       <= {1'b1, {(TERM_W-1){1'b0}}};
            r_sum       <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_j         <= '0;
            r_dc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_log2_base <= i_cfg_wr_data;
            if (i_cmd.clr_vec) begin
                r_cnt <= '0;
                r_max <= {1'b1, {(TERM_W-1){1'b0}}};
                r_sum <= '0;
                r_ovf <= 1'b0;
            end else if (i_cmd.load) begin
                if (r_cnt < CNT_W'(VEC_MAX)) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (term > r_max) r_max <= term;
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (i_cmd.acc) begin
                r_sum <= r_sum + SUM_W'(e);
            end
            if (i_cmd.idx_clr)      r_idx <= '0;
            else if (i_cmd.idx_inc) r_idx <= r_idx + 1'b1;
            if (i_cmd.exp_start)     r_j <= '0;
            else if (i_cmd.exp_step) r_j <= r_j + 1'b1;
            if (i_cmd.div_start)     r_dc <= '0;
            else if (i_cmd.div_step) r_dc <= r_dc + 1'b1;
            if (i_cmd.emit)       r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_start) begin
            r_d <= TERM_W'(r_max - r_rdata);
            r_p <= P_W'(1) << 30;
        end else if (i_cmd.exp_step && r_d[r_j]) begin
            r_p <= p_next;
        end
        if (i_cmd.div_start) begin
            r_num <= NUM_W'({e, 16'h0000}) + NUM_W'(r_sum >> 1);
            r_rem <= '0;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= r_num << 1;
            r_rem <= q_bit ? SUM_W'(rem_sh - {1'b0, r_sum}) : rem_sh[SUM_W-1:0];
            r_q   <= {r_q[Q_W-2:0], q_bit};
        end
        if (i_cmd.emit) begin
            r_out_data  <= {2'b00, IDX_W'(r_idx), prob};
            r_out_last  <= o_sts.idx_last;
            r_out_trunc <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
    assign o_out_trunc = r_out_trunc;

endmodule

@@ rtl/base_b_softmax_unit.sv @@
// Operation: a non-last element is stored and the max updated. On the last element
// of a vector, the sum pass handles each element in turn (read, setup, 20 exponent
// steps, accumulate), then each result is produced in turn (read, setup, 20 exponent
// steps, divider start, 34 division steps, emit), held by any output stall.
// Throughput: one vector at a time; the 2^-d unit and the bit-serial divider set it.
// Reset: i_rst_n synchronous, active low; clears vector state, log2_base to LOG2_BASE_RST (base e^4 in Q4.12).
module base_b_softmax_unit #(
    parameter int VEC_MAX = bbsm_pkg::VEC_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: log2_base, signed Q4.12
    input  logic                             i_cfg_wr_en,
    input  logic [bbsm_pkg::CFG_W-1:0]       i_cfg_wr_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bbsm_pkg::X_W-1:0]         s_axis_tdata,  // [15:0] x_value Q8.8
    input  logic                             s_axis_tlast,  // last_in
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bbsm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [15:0] probability, [21:16] elem_index
    output logic                             m_axis_tlast,  // last_out
    output logic                             m_axis_tuser   // truncated
);
    import bbsm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // controller: accepts a transfer only when idle
    bbsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: the output register lets the next vector load while a result waits
    bbsm_datapath #(
        .VEC_MAX (VEC_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_x           (s_axis_tdata),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_last    (m_axis_tlast),
        .o_out_trunc   (m_axis_tuser)
    );

endmodule

@@ bench/tb_base_b_softmax_unit.sv @@
// Self-checking bench for base_b_softmax_unit: streams vectors in, predicts
// each probability in software and checks every result transfer in order.
// Depends on bbsm_pkg and base_b_softmax_unit.
module tb_base_b_softmax_unit;
    import bbsm_pkg::*;

    typedef struct {
        logic [PROB_W-1:0] prob;
        logic [IDX_W-1:0]  idx;
        logic              last;
        logic              trunc;
    } t_prob_res;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_W-1:0]       i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [X_W-1:0]         s_axis_tdata;   // [15:0] x_value
    logic                   s_axis_tlast;   // last_in
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;   // [15:0] probability, [21:16] elem_index
    logic                   m_axis_tlast;   // last_out
    logic                   m_axis_tuser;   // truncated

    base_b_softmax_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state, mirrors the block's vector buffer
    logic signed [TERM_W-1:0] pred_terms [VEC_MAX_DEF];
    int                       pred_count;
    logic signed [TERM_W-1:0] pred_max;
    logic                     pred_ovf;
    logic signed [CFG_W-1:0]  pred_log2b;
    logic [63:0]              root_tab [FRAC_BITS+1];

    t_prob_res prob_queue [$];
    int  n_err;
    int  n_res;
    int  n_sent;
    int  n_vec;
    int  n_trunc;
    longint cycles;
    bit  idle_enable;   // cleared for a stretch with no idling on either side

    // Own square-root table: r_0 = 2^29, r_i = floor(sqrt(r_(i-1) * 2^30))
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 0;
        hi = 64'd1 << 32;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // 2^-d, d unsigned Q12.20, result unsigned Q1.16
    function automatic logic [31:0] pow2_neg(input logic [31:0] d);
        logic [31:0]  k;
        logic [127:0] p;
        k = d >> FRAC_BITS;
        if (k > 16) return 0;
        p = 128'd1 << 30;
        for (int j = 0; j < FRAC_BITS; j++)
            if (d[j]) p = (p * root_tab[FRAC_BITS-j] + (128'd1 << 29)) >> 30;
        return 32'((p + (128'd1 << (13 + k))) >> (14 + k));
    endfunction

    function automatic void vector_clear();
        pred_count = 0;
        pred_max   = 32'sh8000_0000;
        pred_ovf   = 1'b0;
    endfunction

    // Absorb one accepted element; on the last one queue every probability
    function automatic void softmax_predict(input logic [15:0] x, input logic lst);
        logic signed [63:0] prod;
        logic [31:0] d;
        logic [23:0] sum;
        logic [63:0] e;
        logic [63:0] pr;
        t_prob_res   r;
        if (pred_count < VEC_MAX_DEF) begin
            prod = $signed(x) * pred_log2b;
            pred_terms[pred_count] = prod[31:0];
            if ($signed(prod[31:0]) > pred_max) pred_max = prod[31:0];
            pred_count++;
        end else begin
            pred_ovf = 1'b1;
        end
        if (!lst) return;
        sum = 0;
        for (int i = 0; i < pred_count; i++) begin
            d = 32'(pred_max - pred_terms[i]);
            sum = sum + 24'(pow2_neg(d));
        end
        for (int i = 0; i < pred_count; i++) begin
            d = 32'(pred_max - pred_terms[i]);
            e = pow2_neg(d);
            pr = 0;
            if (sum != 0) begin
                pr = ((e << 16) + (sum >> 1)) / sum;
                if (pr > 65535) pr = 65535;
            end
            r.prob  = pr[15:0];
            r.idx   = i[5:0];
            r.last  = (i + 1 == pred_count);
            r.trunc = pred_ovf;
            prob_queue.push_back(r);
        end
        n_vec++;
        if (pred_ovf) n_trunc++;
        vector_clear();
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR result %0d: %s got %0d expected %0d", n_res, what, got, want);
        n_err++;
    endtask

    // Result checker and random output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_enable && $urandom_range(99) < 23);
            if (m_axis_tvalid && m_axis_tready) begin
                if (prob_queue.size() == 0) begin
                    report_mismatch("unexpected transfer", m_axis_tdata[15:0], -1);
                end else begin
                    t_prob_res w;
                    w = prob_queue.pop_front();
                    if (m_axis_tdata[15:0] !== w.prob)
                        report_mismatch("probability", m_axis_tdata[15:0], w.prob);
                    if (m_axis_tdata[21:16] !== w.idx)
                        report_mismatch("elem_index", m_axis_tdata[21:16], w.idx);
                    if (m_axis_tlast !== w.last)
                        report_mismatch("last_out", m_axis_tlast, w.last);
                    if (m_axis_tuser !== w.trunc)
                        report_mismatch("truncated", m_axis_tuser, w.trunc);
                end
                n_res++;
            end
        end
    end

    // Watchdog: limit allows for up to 64 results plus the sum pass per vector, stalls included
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3_000_000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Send one element; valid held until the transfer completes and left high
    // so that elements can follow back to back
    task automatic send_elem(input logic [15:0] x, input logic lst);
        while (idle_enable && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        softmax_predict(x, lst);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (prob_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Register written only with the block idle
    task automatic set_log2_base(input logic [15:0] v);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pred_log2b = v;
    endtask

    task automatic send_vector(input int len);
        for (int i = 0; i < len; i++)
            send_elem(16'($urandom), i == len - 1);
    endtask

    // Field extremes, single-element vector, equal and spread values
    task automatic test_directed();
        send_elem(16'h0000, 1'b1);
        send_elem(16'h7FFF, 1'b1);
        send_elem(16'h8000, 1'b0);
        send_elem(16'h7FFF, 1'b1);
        send_elem(16'h0100, 1'b0);
        send_elem(16'h0100, 1'b0);
        send_elem(16'h0100, 1'b1);
        send_elem(16'h0000, 1'b0);
        send_elem(16'h0100, 1'b0);
        send_elem(16'hFF00, 1'b0);
        send_elem(16'h0800, 1'b0);
        send_elem(16'hFFFF, 1'b0);
        send_elem(16'h5555, 1'b0);
        send_elem(16'hAAAA, 1'b1);
        // pause until everything is out before the next vector
        wait_drained();
        send_elem(16'h1234, 1'b0);
        send_elem(16'hEDCB, 1'b1);
    endtask

    // Overlong vector: elements past the buffer are dropped, results flagged
    task automatic test_truncation();
        send_vector(VEC_MAX_DEF + 3);
        send_vector(VEC_MAX_DEF);
        send_vector(VEC_MAX_DEF + 1);
    endtask

    // Register sweep including both extremes and zero
    task automatic test_base_settings();
        logic [15:0] bases [5];
        bases = '{16'h7FFF, 16'h8000, 16'h0000, 16'h1000, 16'hF000};
        foreach (bases[b]) begin
            set_log2_base(bases[b]);
            send_vector(1 + $urandom_range(6));
            send_vector(2);
        end
        set_log2_base(LOG2_BASE_RST);
    endtask

    // Mostly short vectors, random data; one stretch with no idling
    task automatic test_random();
        int len;
        while (n_sent < 310) begin
            if (n_sent > 240 && n_sent < 280) idle_enable = 1'b0;
            else idle_enable = 1'b1;
            if (n_vec % 9 == 4) set_log2_base(16'($urandom));
            len = ($urandom_range(15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            send_vector(len);
        end
        idle_enable = 1'b1;
    endtask

    initial begin
        logic [63:0] r;
        r = 64'd1 << 29;
        root_tab[0] = r;
        for (int i = 1; i <= FRAC_BITS; i++) begin
            r = int_sqrt(r << 30);
            root_tab[i] = r;
        end
        n_err = 0; n_res = 0; n_sent = 0; n_vec = 0; n_trunc = 0;
        cycles = 0;
        idle_enable = 1'b1;
        pred_log2b = LOG2_BASE_RST;
        vector_clear();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_truncation();
        test_base_settings();
        test_random();

        wait_drained();
        $display("Covered %0d elements in %0d vectors (%0d truncated), %0d results checked",
                 n_sent, n_vec, n_trunc, n_res);
        if (n_err == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/bbsm_pkg.sv
rtl/bbsm_ctrl.sv
rtl/bbsm_datapath.sv
rtl/base_b_softmax_unit.sv
bench/tb_base_b_softmax_unit.sv
